### src/csvt_pkg.sv
// shared types and constants of the csv field tokenizer
package csvt_pkg;

    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMMENT   = 8'd3;

    localparam logic [7:0] DELIMITER_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;
    localparam logic [7:0] ESCAPE_RESET    = 8'd34;
    localparam logic [7:0] COMMENT_RESET   = 8'd35;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;

    localparam logic [2:0] WARN_NONE         = 3'd0;
    localparam logic [2:0] WARN_BAD_ESCAPE   = 3'd1;
    localparam logic [2:0] WARN_ROGUE_QUOTE  = 3'd2;
    localparam logic [2:0] WARN_QUOTE_UNQ    = 3'd3;
    localparam logic [2:0] WARN_ESCAPE_UNQ   = 3'd4;
    localparam logic [2:0] WARN_UNCLOSED     = 3'd5;

    typedef enum logic [6:0] {
        ST_LINE    = 7'b0000001,
        ST_FSTART  = 7'b0000010,
        ST_UNQ     = 7'b0000100,
        ST_QUOTED  = 7'b0001000,
        ST_QSEEN   = 7'b0010000,
        ST_ESC     = 7'b0100000,
        ST_COMMENT = 7'b1000000
    } parse_state_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       field_end;
        logic       line_end;
        logic       field_was_quoted;
        logic [2:0] warning;
    } out_item_t;

    typedef struct packed {
        logic [7:0] delimiter_char;
        logic [7:0] quote_char;
        logic [7:0] escape_char;
        logic [7:0] comment_char;
    } cfg_t;

endpackage

### src/csvt_cfg.sv
// configuration registers of the csv field tokenizer
module csvt_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [csvt_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [7:0]                    wr_data,
    output csvt_pkg::cfg_t                cfg
);

    csvt_pkg::cfg_t cfg_reg;
    csvt_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                csvt_pkg::REG_DELIMITER: cfg_next.delimiter_char = wr_data;
                csvt_pkg::REG_QUOTE:     cfg_next.quote_char     = wr_data;
                csvt_pkg::REG_ESCAPE:    cfg_next.escape_char    = wr_data;
                csvt_pkg::REG_COMMENT:   cfg_next.comment_char   = wr_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter_char <= csvt_pkg::DELIMITER_RESET;
            cfg_reg.quote_char     <= csvt_pkg::QUOTE_RESET;
            cfg_reg.escape_char    <= csvt_pkg::ESCAPE_RESET;
            cfg_reg.comment_char   <= csvt_pkg::COMMENT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/csvt_parse.sv
// parser state and per-byte decision logic
module csvt_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  csvt_pkg::cfg_t      cfg,
    input  logic                advance,
    input  csvt_pkg::in_item_t  item,
    output csvt_pkg::out_item_t result
);

    csvt_pkg::parse_state_t state_reg;
    csvt_pkg::parse_state_t state_next;
    logic                   quoted_reg;
    logic                   quoted_next;

    logic [7:0] c;
    logic       is_q;
    logic       is_e;
    logic       is_d;
    logic       is_nl;

    logic       unq_emit;
    logic       unq_end;
    logic       unq_last;
    logic [2:0] unq_warn;

    csvt_pkg::parse_state_t qb_state;
    logic                   qb_emit;

    logic do_end;
    logic end_last;
    csvt_pkg::out_item_t res;

    assign c     = item.in_byte;
    assign is_q  = (c == cfg.quote_char);
    assign is_e  = (c == cfg.escape_char);
    assign is_d  = (c == cfg.delimiter_char);
    assign is_nl = (c == csvt_pkg::NEWLINE_CHAR);

    // byte inside an unquoted field
    always_comb
    begin
        unq_emit = 1'b0;
        unq_end  = 1'b0;
        unq_last = 1'b0;
        unq_warn = csvt_pkg::WARN_NONE;
        if (is_q)
        begin
            unq_warn = csvt_pkg::WARN_QUOTE_UNQ;
            unq_emit = 1'b1;
        end
        else if (is_e)
        begin
            unq_warn = csvt_pkg::WARN_ESCAPE_UNQ;
            unq_emit = 1'b1;
        end
        else if (is_d)
        begin
            unq_end = 1'b1;
        end
        else if (is_nl)
        begin
            unq_end  = 1'b1;
            unq_last = 1'b1;
        end
        else
        begin
            unq_emit = 1'b1;
        end
    end

    // byte inside a quoted field
    always_comb
    begin
        if (is_q)
        begin
            qb_state = csvt_pkg::ST_QSEEN;
        end
        else if (is_e)
        begin
            qb_state = csvt_pkg::ST_ESC;
        end
        else
        begin
            qb_state = csvt_pkg::ST_QUOTED;
        end
        qb_emit = !is_q && !is_e;
    end

    always_comb
    begin
        res         = '0;
        state_next  = state_reg;
        quoted_next = quoted_reg;
        do_end      = 1'b0;
        end_last    = 1'b0;

        if (item.end_of_input)
        begin
            unique case (state_reg) inside
                csvt_pkg::ST_FSTART, csvt_pkg::ST_UNQ, csvt_pkg::ST_QSEEN:
                begin
                    do_end   = 1'b1;
                    end_last = 1'b1;
                end
                csvt_pkg::ST_QUOTED, csvt_pkg::ST_ESC:
                begin
                    res.warning = csvt_pkg::WARN_UNCLOSED;
                    do_end      = 1'b1;
                    end_last    = 1'b1;
                end
                default:
                begin
                    state_next  = csvt_pkg::ST_LINE;
                    quoted_next = 1'b0;
                end
            endcase
        end
        else
        begin
            unique case (state_reg) inside
                csvt_pkg::ST_LINE, csvt_pkg::ST_FSTART:
                begin
                    if ((state_reg == csvt_pkg::ST_LINE) && is_nl)
                    begin
                        state_next = csvt_pkg::ST_LINE;
                    end
                    else if ((state_reg == csvt_pkg::ST_LINE) && (c == cfg.comment_char))
                    begin
                        state_next = csvt_pkg::ST_COMMENT;
                    end
                    else if (is_q)
                    begin
                        quoted_next = 1'b1;
                        state_next  = csvt_pkg::ST_QUOTED;
                    end
                    else
                    begin
                        quoted_next    = 1'b0;
                        state_next     = csvt_pkg::ST_UNQ;
                        res.warning    = unq_warn;
                        res.byte_valid = unq_emit;
                        do_end         = unq_end;
                        end_last       = unq_last;
                    end
                end
                csvt_pkg::ST_UNQ:
                begin
                    state_next     = csvt_pkg::ST_UNQ;
                    res.warning    = unq_warn;
                    res.byte_valid = unq_emit;
                    do_end         = unq_end;
                    end_last       = unq_last;
                end
                csvt_pkg::ST_QUOTED:
                begin
                    state_next     = qb_state;
                    res.byte_valid = qb_emit;
                end
                csvt_pkg::ST_QSEEN:
                begin
                    if (is_d)
                    begin
                        do_end = 1'b1;
                    end
                    else if (is_nl)
                    begin
                        do_end   = 1'b1;
                        end_last = 1'b1;
                    end
                    else if (cfg.quote_char == cfg.escape_char)
                    begin
                        if (!is_q)
                        begin
                            res.warning = csvt_pkg::WARN_BAD_ESCAPE;
                        end
                        res.byte_valid = 1'b1;
                        state_next     = csvt_pkg::ST_QUOTED;
                    end
                    else
                    begin
                        res.warning    = csvt_pkg::WARN_ROGUE_QUOTE;
                        state_next     = qb_state;
                        res.byte_valid = qb_emit;
                    end
                end
                csvt_pkg::ST_ESC:
                begin
                    if (!is_q && !is_e)
                    begin
                        res.warning = csvt_pkg::WARN_BAD_ESCAPE;
                    end
                    res.byte_valid = 1'b1;
                    state_next     = csvt_pkg::ST_QUOTED;
                end
                csvt_pkg::ST_COMMENT:
                begin
                    if (is_nl)
                    begin
                        state_next = csvt_pkg::ST_LINE;
                    end
                end
                default:
                begin
                    state_next  = csvt_pkg::ST_LINE;
                    quoted_next = 1'b0;
                end
            endcase
        end

        if (res.byte_valid)
        begin
            res.out_byte = c;
        end

        // close the open field
        if (do_end)
        begin
            res.field_end        = 1'b1;
            res.line_end         = end_last;
            res.field_was_quoted = quoted_next;
            quoted_next          = 1'b0;
            state_next           = end_last ? csvt_pkg::ST_LINE : csvt_pkg::ST_FSTART;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= csvt_pkg::ST_LINE;
            quoted_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg  <= state_next;
            quoted_reg <= quoted_next;
        end
    end

    assign result = res;

endmodule

### src/csv_field_tokenizer_top.sv
// top level of the csv field tokenizer
//
// input channel: in_valid / in_stall carry one request per byte in in_data,
// either a text byte or the end-of-input mark that closes an open field.
// output channel: out_valid / out_stall carry exactly one result per request
// in out_data: at most one content byte, field and line end flags, whether
// the ended field was quoted, and a warning code.
// configuration: cfg_valid / cfg_ready with cfg_index and cfg_data write the
// delimiter, quote, escape and comment characters; cfg_ready is always high
// and unknown indexes are ignored. write only while the block is idle.
// an accepted request is held in the input register, parsed, and its result
// is held in the result register. throughput: one request per cycle unless
// the receiver stalls, set by the single parse step in between.
// reset: the parser returns to line start, no field is open, both pipeline
// registers empty, configuration goes back to comma, double quote, double
// quote and hash.
// receiver stall: the result register holds, the input register fills and
// in_stall rises once both are occupied; nothing is dropped.
module csv_field_tokenizer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  csvt_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output csvt_pkg::out_item_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [csvt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);

    csvt_pkg::cfg_t      cfg;
    csvt_pkg::in_item_t  item_reg;
    logic                item_valid_reg;
    csvt_pkg::out_item_t res_reg;
    logic                res_valid_reg;
    csvt_pkg::out_item_t result;
    logic                advance;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall  = item_valid_reg && !advance;

    csvt_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    csvt_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .item    (item_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!res_valid_reg || !out_stall)
        begin
            res_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

### src/csvt_checker.sv
// port-level assertions for the csv field tokenizer
module csvt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input csvt_pkg::out_item_t            out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    // line end and quoted flag only come with a field end
    a_end_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.field_end |->
            !out_data.line_end && !out_data.field_was_quoted)
        else $error("line end or quoted flag without field end");

    // content byte and field end never share a result
    a_byte_or_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.byte_valid && out_data.field_end)
            && (out_data.byte_valid || out_data.out_byte == 8'd0))
        else $error("content byte with field end or stray byte");

    // unclosed warning closes the record
    a_unclosed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.warning == csvt_pkg::WARN_UNCLOSED |->
            out_data.field_end && out_data.line_end && out_data.field_was_quoted)
        else $error("unclosed warning without record end");

    // a request accepted into an empty pipeline shows up at the output after the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> ##1 out_valid)
        else $error("result missing after accepted request");

endmodule

bind csv_field_tokenizer_top csvt_checker u_csvt_checker (.*);
